### rtl/escape_lz_byte_decompressor_macros.svh
// Assertion macros for the escape-coded LZ byte decompressor.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ESCAPE_LZ_BYTE_DECOMPRESSOR_MACROS_SVH
`define ESCAPE_LZ_BYTE_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ELZD_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("elzd: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ELZD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("elzd: assertion failed");

`else

`define ELZD_ASSERT_IMPLIES(label, clock, resetn, ante, cons)
`define ELZD_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

### rtl/elzd_pkg.sv
// Shared types and constants for the escape-coded LZ byte decompressor.
// No dependencies; used by elzd_history and escape_lz_byte_decompressor.
`default_nettype none

package elzd_pkg;

    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int BYTE_W            = 8;
    localparam int LANES             = 4;
    localparam int LANE_CNT_W        = 3;
    localparam int DATA_W            = LANES * BYTE_W;

    // Register index decoded from the word address.
    localparam logic REG_ESCAPE_IDX = 1'b0;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hAD;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DIST  = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    typedef enum logic [1:0] {
        PH_LIT  = 2'd0,
        PH_DIST = 2'd1,
        PH_LEN  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0]     data;
        logic [LANE_CNT_W-1:0] count;
        logic                  run_end;
        logic                  stream_end;
        logic [1:0]            status;
    } result_t;

endpackage

`default_nettype wire

### rtl/escape_lz_byte_decompressor.sv
// Top level of the escape-coded LZ byte decompressor.
// Depends on elzd_pkg, elzd_history and escape_lz_byte_decompressor_macros.svh.
// Usage:
//   Compressed bytes arrive on the s_axis stream, one byte per request, with
//   s_axis_tlast marking the final byte of a stream. Decompressed bytes leave
//   on the m_axis stream, packed up to four per request, with a byte count,
//   a run-end flag, a status code in m_axis_tuser and m_axis_tlast on the
//   final request of a stream. The user must set the escape code through the
//   APB port at byte address 0 only while the block is idle (not enforced).
//   The escape code resets to 0xAD.
//   A literal byte produces its result in the cycle after it is accepted, and
//   literal bytes stream at one per cycle while m_axis_tready stays high. A copy
//   token stops input while the history memory is read back byte by byte into
//   groups of four; the reads for a group wait until the last byte of the group
//   before it has arrived, bounded by the single read port and the registered read.
// Reset and stalls:
//   Reset returns the decoder state and the escape code to their initial values;
//   the history memory is not cleared, as no entry is read before it is written.
//   A low m_axis_tready holds the output request, stalls input and pauses a copy.
`default_nettype none

`include "escape_lz_byte_decompressor_macros.svh"

module escape_lz_byte_decompressor #(
    parameter int HISTORY_DEPTH = elzd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tlast,   // end_of_stream
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // [31:0] out_bytes, [34:32] byte_count,
                                             // [35] run_end, [39:36] zero
    output logic             m_axis_tlast,   // stream_end
    output logic      [1:0]  m_axis_tuser,   // [1:0] status
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int BW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] DEPTH_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [BW-1:0] DEPTH_BW   = BW'(HISTORY_DEPTH);
    localparam int BYTE_W = elzd_pkg::BYTE_W;
    localparam int CNT_W  = elzd_pkg::LANE_CNT_W;

    // Control state.
    elzd_pkg::state_t  state_reg,  state_next;
    elzd_pkg::phase_t  phase_reg,  phase_next;
    logic [BYTE_W-1:0] dist_reg,   dist_next;
    logic              err_reg,    err_next;
    logic [AW-1:0]     wp_reg,     wp_next;
    logic [BW-1:0]     bw_reg,     bw_next;
    logic [BYTE_W-1:0] esc_reg;

    // Output register.
    elzd_pkg::result_t out_reg,       out_next;
    logic              out_valid_reg, out_valid_next;

    // Copy engine.
    logic [7:0]        issue_left_reg,  issue_left_next;
    logic [7:0]        arrive_left_reg, arrive_left_next;
    logic [AW-1:0]     rd_addr_reg,     rd_addr_next;
    logic              pend_reg,        pend_next;
    logic [elzd_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  acc_cnt_reg,     acc_cnt_next;
    logic              acc_done_reg,    acc_done_next;
    logic              acc_last_reg,    acc_last_next;
    logic              copy_eos_reg,    copy_eos_next;

    // History memory ports.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // Decode helpers.
    logic              out_free;
    logic              in_acc;
    logic              eos;
    logic [BYTE_W-1:0] in_byte;
    logic              emit;
    logic              lit;
    logic [BYTE_W-1:0] lit_byte;
    logic              copy_start;
    logic [1:0]        status;
    logic [AW-1:0]     src_addr;
    logic [AW-1:0]     wp_inc;
    logic [BW-1:0]     bw_inc;
    logic              push;
    logic              completes;
    logic              cfg_we;

    elzd_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == elzd_pkg::ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign eos           = s_axis_tlast;
    assign in_byte       = s_axis_tdata;

    assign wp_inc = (wp_reg == DEPTH_LAST) ? '0 : wp_reg + AW'(1);
    assign bw_inc = (bw_reg == DEPTH_BW) ? bw_reg : bw_reg + BW'(1);

    // Start of a copy: the entry held_distance bytes behind the write pointer.
    always_comb
    begin
        if (wp_reg >= AW'(dist_reg))
        begin
            src_addr = wp_reg - AW'(dist_reg);
        end
        else
        begin
            src_addr = AW'((AW + 1)'(wp_reg) + (AW + 1)'(HISTORY_DEPTH)
                           - (AW + 1)'(dist_reg));
        end
    end

    assign push      = acc_done_reg && out_free;
    assign completes = pend_reg && ((acc_cnt_reg == CNT_W'(elzd_pkg::LANES - 1))
                                    || (arrive_left_reg == 8'd1));

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        dist_next        = dist_reg;
        err_next         = err_reg;
        wp_next          = wp_reg;
        bw_next          = bw_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        issue_left_next  = issue_left_reg;
        arrive_left_next = arrive_left_reg;
        rd_addr_next     = rd_addr_reg;
        pend_next        = 1'b0;
        acc_next         = acc_reg;
        acc_cnt_next     = acc_cnt_reg;
        acc_done_next    = acc_done_reg;
        acc_last_next    = acc_last_reg;
        copy_eos_next    = copy_eos_reg;
        mem_we           = 1'b0;
        mem_waddr        = wp_reg;
        mem_wdata        = in_byte;
        mem_re           = 1'b0;
        mem_raddr        = rd_addr_reg;
        emit             = 1'b0;
        lit              = 1'b0;
        lit_byte         = in_byte;
        copy_start       = 1'b0;
        status           = elzd_pkg::STATUS_OK;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            elzd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (err_reg)
                    begin
                        // Input is dropped until the end of the stream.
                        if (eos)
                        begin
                            status = elzd_pkg::STATUS_DIST;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            elzd_pkg::PH_DIST:
                            begin
                                if (in_byte == '0)
                                begin
                                    lit        = 1'b1;
                                    lit_byte   = esc_reg;
                                    phase_next = elzd_pkg::PH_LIT;
                                end
                                else
                                begin
                                    dist_next  = in_byte;
                                    phase_next = elzd_pkg::PH_LEN;
                                end
                            end
                            elzd_pkg::PH_LEN:
                            begin
                                phase_next = elzd_pkg::PH_LIT;
                                if (BW'(dist_reg) > bw_reg)
                                begin
                                    status = elzd_pkg::STATUS_DIST;
                                end
                                else if (in_byte != '0)
                                begin
                                    copy_start = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = elzd_pkg::PH_LIT;
                                if (in_byte == esc_reg)
                                begin
                                    phase_next = elzd_pkg::PH_DIST;
                                end
                                else
                                begin
                                    lit = 1'b1;
                                end
                            end
                        endcase

                        if (eos && (status == elzd_pkg::STATUS_OK)
                            && (phase_next != elzd_pkg::PH_LIT))
                        begin
                            status = elzd_pkg::STATUS_TRUNC;
                        end
                    end

                    emit = lit || (status != elzd_pkg::STATUS_OK) || (eos && !copy_start);

                    if (lit)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = lit_byte;
                        wp_next   = wp_inc;
                        bw_next   = bw_inc;
                    end

                    if (emit)
                    begin
                        out_next.data       = lit ? elzd_pkg::DATA_W'(lit_byte) : '0;
                        out_next.count      = lit ? CNT_W'(1) : '0;
                        out_next.run_end    = 1'b1;
                        out_next.stream_end = eos;
                        out_next.status     = status;
                        out_valid_next      = 1'b1;
                    end

                    if (copy_start)
                    begin
                        state_next       = elzd_pkg::ST_COPY;
                        issue_left_next  = in_byte;
                        arrive_left_next = in_byte;
                        rd_addr_next     = src_addr;
                        copy_eos_next    = eos;
                        acc_next         = '0;
                        acc_cnt_next     = '0;
                        acc_done_next    = 1'b0;
                        acc_last_next    = 1'b0;
                    end

                    if ((status == elzd_pkg::STATUS_DIST) && !eos)
                    begin
                        err_next = 1'b1;
                    end

                    if (eos && !copy_start)
                    begin
                        wp_next    = '0;
                        bw_next    = '0;
                        phase_next = elzd_pkg::PH_LIT;
                        dist_next  = '0;
                        err_next   = 1'b0;
                    end
                end
            end

            elzd_pkg::ST_COPY:
            begin
                // A finished group moves to the output register.
                if (push)
                begin
                    out_next.data       = acc_reg;
                    out_next.count      = acc_cnt_reg;
                    out_next.run_end    = acc_last_reg;
                    out_next.stream_end = acc_last_reg && copy_eos_reg;
                    out_next.status     = elzd_pkg::STATUS_OK;
                    out_valid_next      = 1'b1;
                    acc_next            = '0;
                    acc_cnt_next        = '0;
                    acc_done_next       = 1'b0;
                    acc_last_next       = 1'b0;
                    if (acc_last_reg)
                    begin
                        state_next = elzd_pkg::ST_IDLE;
                    end
                end

                // A byte read last cycle is appended to history and to the group.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    wp_next   = wp_inc;
                    bw_next   = bw_inc;
                    for (int l = 0; l < elzd_pkg::LANES; l++)
                    begin
                        if (acc_cnt_reg == CNT_W'(l))
                        begin
                            acc_next[l*BYTE_W +: BYTE_W] = mem_rdata;
                        end
                    end
                    acc_cnt_next     = acc_cnt_reg + CNT_W'(1);
                    arrive_left_next = arrive_left_reg - 8'd1;
                    if (completes)
                    begin
                        acc_done_next = 1'b1;
                        acc_last_next = (arrive_left_reg == 8'd1);
                    end
                    if ((arrive_left_reg == 8'd1) && copy_eos_reg)
                    begin
                        wp_next   = '0;
                        bw_next   = '0;
                        dist_next = '0;
                    end
                end

                // Next read, unless the group it would land in is not free.
                if ((issue_left_reg != 8'd0) && (!acc_done_reg || push) && !completes)
                begin
                    mem_re          = 1'b1;
                    pend_next       = 1'b1;
                    issue_left_next = issue_left_reg - 8'd1;
                    rd_addr_next    = (rd_addr_reg == DEPTH_LAST) ? '0
                                                                  : rd_addr_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = elzd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= elzd_pkg::ST_IDLE;
            phase_reg       <= elzd_pkg::PH_LIT;
            dist_reg        <= '0;
            err_reg         <= 1'b0;
            wp_reg          <= '0;
            bw_reg          <= '0;
            out_valid_reg   <= 1'b0;
            issue_left_reg  <= '0;
            arrive_left_reg <= '0;
            pend_reg        <= 1'b0;
            acc_cnt_reg     <= '0;
            acc_done_reg    <= 1'b0;
            acc_last_reg    <= 1'b0;
            copy_eos_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            dist_reg        <= dist_next;
            err_reg         <= err_next;
            wp_reg          <= wp_next;
            bw_reg          <= bw_next;
            out_valid_reg   <= out_valid_next;
            issue_left_reg  <= issue_left_next;
            arrive_left_reg <= arrive_left_next;
            pend_reg        <= pend_next;
            acc_cnt_reg     <= acc_cnt_next;
            acc_done_reg    <= acc_done_next;
            acc_last_reg    <= acc_last_next;
            copy_eos_reg    <= copy_eos_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        acc_reg     <= acc_next;
        rd_addr_reg <= rd_addr_next;
    end

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == elzd_pkg::REG_ESCAPE_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= elzd_pkg::ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            esc_reg <= pwdata[BYTE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == elzd_pkg::REG_ESCAPE_IDX) ? 32'(esc_reg) : '0;

    // Output ports.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.run_end, out_reg.count, out_reg.data};
    assign m_axis_tlast  = out_reg.stream_end;
    assign m_axis_tuser  = out_reg.status;

    // Checks.
    `ELZD_ASSERT_IMPLIES(a_copy_blocks_input, clk, rst_n, state_reg == elzd_pkg::ST_COPY, !s_axis_tready)
    `ELZD_ASSERT_IMPLIES(a_arrival_has_room, clk, rst_n, pend_reg, !acc_done_reg)
    `ELZD_ASSERT_IMPLIES(a_issue_within_arrive, clk, rst_n, state_reg == elzd_pkg::ST_COPY, issue_left_reg <= arrive_left_reg)
    `ELZD_ASSERT_IMPLIES(a_count_saturates, clk, rst_n, 1'b1, bw_reg <= DEPTH_BW)
    `ELZD_ASSERT_NEXT(a_last_push_idles, clk, rst_n, (state_reg == elzd_pkg::ST_COPY) && push && acc_last_reg, (state_reg == elzd_pkg::ST_IDLE) && m_axis_tvalid && m_axis_tdata[35])

endmodule

`default_nettype wire

### rtl/elzd_history.sv
// Output history memory: one write port, one registered read port.
// Forwards a write that hits the address read in the same cycle; uses elzd_pkg.
`default_nettype none

module elzd_history #(
    parameter int HISTORY_DEPTH = elzd_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [elzd_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [elzd_pkg::BYTE_W-1:0] rdata
);

    logic [elzd_pkg::BYTE_W-1:0] mem [HISTORY_DEPTH];
    logic [elzd_pkg::BYTE_W-1:0] q_reg;
    logic [elzd_pkg::BYTE_W-1:0] fwd_reg;
    logic                        hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[raddr];
        end
        fwd_reg <= wdata;
    end

    // A read of the entry being written this cycle must see the new byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (re)
        begin
            hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = hit_reg ? fwd_reg : q_reg;

endmodule

`default_nettype wire
